// ----- hw/rtl/dual_imu_odometry_update_assert.svh -----
// Assertion macros shared by the odometry update RTL.
`ifndef DUAL_IMU_ODOMETRY_UPDATE_ASSERT_SVH
`define DUAL_IMU_ODOMETRY_UPDATE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DIU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DIU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/diu_pkg.sv -----
// Shared types, constants and helper functions of the odometry update block.
`default_nettype none

package diu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int POS_WIDTH_DEF = 48;

    localparam int HEAD_W  = 16;
    localparam int COUNT_W = 32;
    localparam int AVG_W   = 33;
    localparam int FIFO_W  = 2 * HEAD_W + AVG_W;
    localparam int FIFO_DEPTH = 2;

    // pi * 2^44, truncated
    localparam logic [63:0] PI44 = 64'h0000_3243_F6A8_885A;
    localparam int FULL_CDEG = 36000;
    localparam int HALF_CDEG = 18000;

    localparam int CDEG_DIV_W = 15;
    localparam int SER_DIV_W  = 10;
    localparam int DIV_DIGIT  = 4;
    localparam int TERM_LAST  = 11;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_NUM,
        B_RAD_DIV,
        B_ANGLE,
        B_MEAN,
        B_QUAD,
        B_SQUARE,
        B_TERM_MUL,
        B_TERM_START,
        B_TERM_DIV,
        B_FINISH,
        B_STEP,
        B_ACC
    } back_state_t;

    // One full turn in Q3.f radians, rounded.
    function automatic logic [63:0] full_turn(input int f);
        return ((PI44 << 1) + (64'd1 << (43 - f))) >> (44 - f);
    endfunction

    // Series divisor (n+1)(n+2) for term j of the sine or cosine expansion.
    function automatic logic [SER_DIV_W-1:0] series_div(input logic [3:0] j,
                                                        input logic is_sin);
        logic [4:0] a;
        a = is_sin ? {j, 1'b0} : ({j, 1'b0} - 5'd1);
        return SER_DIV_W'(a) * SER_DIV_W'(a + 5'd1);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/diu_fifo.sv -----
// Short queue of decoded samples between the front and the back.
`default_nettype none

module diu_fifo #(
    parameter int WIDTH = diu_pkg::FIFO_W,
    parameter int DEPTH = diu_pkg::FIFO_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output diu_pkg::fifo_stat_t   stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- hw/rtl/diu_front.sv -----
// Front end: takes samples, mirrors headings and averages encoder deltas.
`default_nettype none

module diu_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [diu_pkg::HEAD_W-1:0]    left_heading,
    input  wire logic [diu_pkg::HEAD_W-1:0]    right_heading,
    input  wire logic signed [diu_pkg::COUNT_W-1:0] left_count,
    input  wire logic signed [diu_pkg::COUNT_W-1:0] right_count,
    input  wire diu_pkg::fifo_stat_t           stat,
    output logic                               push,
    output logic [diu_pkg::FIFO_W-1:0]         push_data
);

    localparam int HW = diu_pkg::HEAD_W;
    localparam int CW = diu_pkg::COUNT_W;
    localparam logic [HW-1:0] FULL = HW'(diu_pkg::FULL_CDEG);

    logic signed [CW-1:0] prev_left_reg, prev_right_reg;
    logic [HW-1:0]        m_left, m_right;
    logic signed [CW+1:0] delta_sum;
    logic signed [CW+1:0] half_sum;

    assign in_stall = stat.full;
    assign push     = in_valid && !stat.full;

    // mirror: |36000 - h|
    assign m_left  = (left_heading <= FULL) ? (FULL - left_heading) : (left_heading - FULL);
    assign m_right = (right_heading <= FULL) ? (FULL - right_heading)
                                             : (right_heading - FULL);

    assign delta_sum = ((CW + 2)'(left_count) - (CW + 2)'(prev_left_reg))
                     + ((CW + 2)'(right_count) - (CW + 2)'(prev_right_reg));
    // halve, truncating toward zero
    assign half_sum  = (delta_sum + (CW + 2)'(delta_sum[CW + 1])) >>> 1;

    assign push_data = {m_left, m_right, half_sum[diu_pkg::AVG_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
        end
        else if (push)
        begin
            prev_left_reg  <= left_count;
            prev_right_reg <= right_count;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/diu_div.sv -----
// Digit-serial unsigned divider, four quotient bits per cycle.
`default_nettype none

module diu_div #(
    parameter int DVD_W = 34,
    parameter int DVS_W = diu_pkg::SER_DIV_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    localparam int DIG   = diu_pkg::DIV_DIGIT;
    localparam int STEPS = (DVD_W + DIG - 1) / DIG;
    localparam int PW    = STEPS * DIG;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PW-1:0]    sh_reg, sh_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    always_comb
    begin
        logic [DVS_W:0]   t;
        logic [DVS_W-1:0] r;
        logic [PW-1:0]    s;
        r = rem_reg;
        s = sh_reg;
        for (int i = 0; i < DIG; i++)
        begin
            t = {r, s[PW-1]};
            s = {s[PW-2:0], 1'b0};
            if (t >= {1'b0, dvs_reg})
            begin
                t    = t - {1'b0, dvs_reg};
                s[0] = 1'b1;
            end
            r = t[DVS_W-1:0];
        end
        sh_next  = s;
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1)) && !start;
            if (start)
            begin
                cnt_reg <= CNT_W'(STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= PW'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = sh_reg[DVD_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/diu_back.sv -----
// Back end: heading fusion, sine/cosine series and position accumulation.
`default_nettype none

`include "dual_imu_odometry_update_assert.svh"

module diu_back #(
    parameter int FRAC_BITS = diu_pkg::FRAC_BITS_DEF,
    parameter int POS_WIDTH = diu_pkg::POS_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire diu_pkg::fifo_stat_t         stat,
    input  wire logic [diu_pkg::FIFO_W-1:0]  pop_data,
    output logic                             pop,
    input  wire logic [FRAC_BITS+2:0]        offset,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [FRAC_BITS+2:0]             theta,
    output logic signed [POS_WIDTH-1:0]      pos_x,
    output logic signed [POS_WIDTH-1:0]      pos_y
);

    localparam int F      = FRAC_BITS;
    localparam int ANG_W  = F + 3;
    localparam int EW     = ANG_W + 3;
    localparam int HW     = diu_pkg::HEAD_W;
    localparam int AW     = diu_pkg::AVG_W;
    localparam int RDW    = F + 17;
    localparam int SHR    = 44 - F;
    localparam int PRD_W  = HW + 23;
    localparam int TDW    = 34;
    localparam int SW     = 35;
    localparam int TRIG_W = F + 3;
    localparam int STEP_W = AW + TRIG_W;
    localparam int SAT_W  = ((POS_WIDTH > STEP_W) ? POS_WIDTH : STEP_W) + 1;

    localparam logic [63:0]      TURN64  = diu_pkg::full_turn(FRAC_BITS);
    localparam logic [ANG_W-1:0] TURN    = TURN64[ANG_W-1:0];
    localparam logic [63:0]      RAD_RND = 64'(diu_pkg::HALF_CDEG) << (43 - F);
    localparam logic [22:0]      PI_LO   = diu_pkg::PI44[22:0];
    localparam logic [22:0]      PI_HI   = diu_pkg::PI44[45:23];
    localparam logic [33:0]      HP      = 34'(diu_pkg::PI44 >> 15);
    localparam logic [31:0]      Q30_ONE = 32'h4000_0000;
    localparam logic signed [SAT_W-1:0] PMAX =
        {{(SAT_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] PMIN = ~PMAX;

    diu_pkg::back_state_t state_reg, state_next;

    logic [HW-1:0]          ml_reg, mr_reg;
    logic signed [AW-1:0]   avg_reg;
    logic [PRD_W-1:0]       pl_lo_reg, pl_hi_reg, pr_lo_reg, pr_hi_reg;
    logic [ANG_W-1:0]       a1_reg, a2_reg, theta_reg, theta_out_reg;
    logic [1:0]             quad_reg;
    logic [31:0]            r_reg, r2_reg, ts_reg, tc_reg;
    logic [TDW-1:0]         ps_reg, pc_reg;
    logic signed [SW-1:0]   sum_s_reg, sum_c_reg;
    logic [3:0]             j_reg;
    logic signed [TRIG_W-1:0] cs_reg, sn_reg;
    logic signed [STEP_W-1:0] stepx_reg, stepy_reg;
    logic signed [POS_WIDTH-1:0] acc_x_reg, acc_y_reg;
    logic                   out_valid_reg;

    logic rad_start, term_start, out_load;
    logic rad_done_l, rad_done_r, term_done_s, term_done_c;
    logic [RDW-1:0] rad_q_l, rad_q_r;
    logic [TDW-1:0] term_q_s, term_q_c;
    logic [63:0]    num_l, num_r;
    logic [ANG_W-1:0] a_l, a_r, off_m, theta_mean;
    logic [31:0]    r_next;
    logic [1:0]     quad_next;
    logic signed [TRIG_W-1:0] cs_next, sn_next;
    logic signed [POS_WIDTH-1:0] acc_x_next, acc_y_next;
    logic [63:0]    sq_prod, ps_prod, pc_prod;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            diu_pkg::B_IDLE:       if (!stat.empty) state_next = diu_pkg::B_MUL;
            diu_pkg::B_MUL:        state_next = diu_pkg::B_NUM;
            diu_pkg::B_NUM:        state_next = diu_pkg::B_RAD_DIV;
            diu_pkg::B_RAD_DIV:    if (rad_done_l) state_next = diu_pkg::B_ANGLE;
            diu_pkg::B_ANGLE:      state_next = diu_pkg::B_MEAN;
            diu_pkg::B_MEAN:       state_next = diu_pkg::B_QUAD;
            diu_pkg::B_QUAD:       state_next = diu_pkg::B_SQUARE;
            diu_pkg::B_SQUARE:     state_next = diu_pkg::B_TERM_MUL;
            diu_pkg::B_TERM_MUL:   state_next = diu_pkg::B_TERM_START;
            diu_pkg::B_TERM_START: state_next = diu_pkg::B_TERM_DIV;
            diu_pkg::B_TERM_DIV:
            begin
                if (term_done_s)
                begin
                    state_next = (j_reg == 4'(diu_pkg::TERM_LAST)) ? diu_pkg::B_FINISH
                                                                  : diu_pkg::B_TERM_MUL;
                end
            end
            diu_pkg::B_FINISH:     state_next = diu_pkg::B_STEP;
            diu_pkg::B_STEP:       state_next = diu_pkg::B_ACC;
            diu_pkg::B_ACC:        if (!out_valid_reg || !out_stall) state_next = diu_pkg::B_IDLE;
            default:               state_next = diu_pkg::B_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        pop        = 1'b0;
        rad_start  = 1'b0;
        term_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            diu_pkg::B_IDLE:       pop = !stat.empty;
            diu_pkg::B_NUM:        rad_start = 1'b1;
            diu_pkg::B_TERM_START: term_start = 1'b1;
            diu_pkg::B_ACC:        out_load = !out_valid_reg || !out_stall;
            default:               pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= diu_pkg::B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------- heading to radians ----------------
    assign num_l = ({{(64 - PRD_W){1'b0}}, pl_hi_reg} << 23)
                 + {{(64 - PRD_W){1'b0}}, pl_lo_reg} + RAD_RND;
    assign num_r = ({{(64 - PRD_W){1'b0}}, pr_hi_reg} << 23)
                 + {{(64 - PRD_W){1'b0}}, pr_lo_reg} + RAD_RND;

    diu_div #(.DVD_W(RDW), .DVS_W(diu_pkg::CDEG_DIV_W)) u_rad_div_l (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rad_start),
        .dividend (num_l[SHR +: RDW]),
        .divisor  (diu_pkg::CDEG_DIV_W'(diu_pkg::HALF_CDEG)),
        .done     (rad_done_l),
        .quotient (rad_q_l)
    );

    diu_div #(.DVD_W(RDW), .DVS_W(diu_pkg::CDEG_DIV_W)) u_rad_div_r (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rad_start),
        .dividend (num_r[SHR +: RDW]),
        .divisor  (diu_pkg::CDEG_DIV_W'(diu_pkg::HALF_CDEG)),
        .done     (rad_done_r),
        .quotient (rad_q_r)
    );

    assign off_m = (offset >= TURN) ? (offset - TURN) : offset;

    always_comb
    begin
        logic [ANG_W-1:0] rl, rr;
        logic [ANG_W:0]   wl, wr;
        rl = rad_q_l[ANG_W-1:0];
        rr = rad_q_r[ANG_W-1:0];
        // a full turn wraps to zero
        if (rl >= TURN) rl = '0;
        if (rr >= TURN) rr = '0;
        wl = {1'b0, rl} + {1'b0, TURN} - {1'b0, off_m};
        wr = {1'b0, rr} + {1'b0, TURN} - {1'b0, off_m};
        a_l = (rl >= off_m) ? (rl - off_m) : wl[ANG_W-1:0];
        a_r = (rr >= off_m) ? (rr - off_m) : wr[ANG_W-1:0];
    end

    // ---------------- circular mean ----------------
    always_comb
    begin
        logic signed [EW-1:0] t_s, a1s, a2s, d, d2, m2, th;
        t_s = signed'(EW'(TURN));
        a1s = signed'(EW'(a1_reg));
        a2s = signed'(EW'(a2_reg));
        d   = a2s - a1s;
        d2  = d <<< 1;
        // take the shorter arc
        if (d2 > t_s)
        begin
            d = d - t_s;
        end
        else if (d2 < -t_s)
        begin
            d = d + t_s;
        end
        d2 = d <<< 1;
        m2 = (a1s <<< 1) + d;
        if (m2 < 0)
        begin
            m2 = m2 + (t_s <<< 1);
        end
        else if (m2 >= (t_s <<< 1))
        begin
            m2 = m2 - (t_s <<< 1);
        end
        th = (m2 + EW'(1)) >>> 1;
        if (th >= t_s)
        begin
            th = th - t_s;
        end
        // opposite headings: zero mean vector reads as pi
        if (d2 == t_s || d2 == -t_s)
        begin
            theta_mean = TURN >> 1;
        end
        else
        begin
            theta_mean = th[ANG_W-1:0];
        end
    end

    // ---------------- quadrant split ----------------
    always_comb
    begin
        logic [33:0] th30;
        th30 = 34'(theta_reg) << (30 - F);
        if (th30 >= 34'(HP * 4))
        begin
            quad_next = 2'd0;
            r_next    = 32'(th30 - 34'(HP * 4));
        end
        else if (th30 >= 34'(HP * 3))
        begin
            quad_next = 2'd3;
            r_next    = 32'(th30 - 34'(HP * 3));
        end
        else if (th30 >= 34'(HP * 2))
        begin
            quad_next = 2'd2;
            r_next    = 32'(th30 - 34'(HP * 2));
        end
        else if (th30 >= HP)
        begin
            quad_next = 2'd1;
            r_next    = 32'(th30 - HP);
        end
        else
        begin
            quad_next = 2'd0;
            r_next    = 32'(th30);
        end
    end

    // ---------------- series terms ----------------
    assign sq_prod = 64'(r_reg) * 64'(r_reg);
    assign ps_prod = 64'(ts_reg) * 64'(r2_reg);
    assign pc_prod = 64'(tc_reg) * 64'(r2_reg);

    diu_div #(.DVD_W(TDW), .DVS_W(diu_pkg::SER_DIV_W)) u_term_div_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (term_start),
        .dividend (ps_reg),
        .divisor  (diu_pkg::series_div(j_reg, 1'b1)),
        .done     (term_done_s),
        .quotient (term_q_s)
    );

    diu_div #(.DVD_W(TDW), .DVS_W(diu_pkg::SER_DIV_W)) u_term_div_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (term_start),
        .dividend (pc_reg),
        .divisor  (diu_pkg::series_div(j_reg, 1'b0)),
        .done     (term_done_c),
        .quotient (term_q_c)
    );

    // ---------------- round to Q(F) and map by quadrant ----------------
    always_comb
    begin
        logic [33:0] vs, vc;
        logic [34:0] rs, rc;
        logic signed [TRIG_W-1:0] s, c;
        vs = sum_s_reg[SW-1] ? '0 : sum_s_reg[33:0];
        vc = sum_c_reg[SW-1] ? '0 : sum_c_reg[33:0];
        rs = {1'b0, vs} + (35'd1 << (29 - F));
        rc = {1'b0, vc} + (35'd1 << (29 - F));
        s  = signed'({1'b0, rs[30 - F +: F + 2]});
        c  = signed'({1'b0, rc[30 - F +: F + 2]});
        case (quad_reg)
            2'd0:
            begin
                cs_next = c;
                sn_next = s;
            end
            2'd1:
            begin
                cs_next = -s;
                sn_next = c;
            end
            2'd2:
            begin
                cs_next = -c;
                sn_next = -s;
            end
            default:
            begin
                cs_next = s;
                sn_next = -c;
            end
        endcase
    end

    // ---------------- saturating accumulate ----------------
    always_comb
    begin
        logic signed [SAT_W-1:0] sx, sy;
        sx = SAT_W'(acc_x_reg) + SAT_W'(stepx_reg);
        sy = SAT_W'(acc_y_reg) + SAT_W'(stepy_reg);
        if (sx > PMAX) sx = PMAX;
        else if (sx < PMIN) sx = PMIN;
        if (sy > PMAX) sy = PMAX;
        else if (sy < PMIN) sy = PMIN;
        acc_x_next = sx[POS_WIDTH-1:0];
        acc_y_next = sy[POS_WIDTH-1:0];
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            diu_pkg::B_IDLE:
            begin
                if (pop)
                begin
                    ml_reg  <= pop_data[AW + 2 * HW - 1 -: HW];
                    mr_reg  <= pop_data[AW + HW - 1 -: HW];
                    avg_reg <= signed'(pop_data[AW-1:0]);
                end
            end
            diu_pkg::B_MUL:
            begin
                pl_lo_reg <= PRD_W'(ml_reg) * PRD_W'(PI_LO);
                pl_hi_reg <= PRD_W'(ml_reg) * PRD_W'(PI_HI);
                pr_lo_reg <= PRD_W'(mr_reg) * PRD_W'(PI_LO);
                pr_hi_reg <= PRD_W'(mr_reg) * PRD_W'(PI_HI);
            end
            diu_pkg::B_ANGLE:
            begin
                a1_reg <= a_l;
                a2_reg <= a_r;
            end
            diu_pkg::B_MEAN:
            begin
                theta_reg <= theta_mean;
            end
            diu_pkg::B_QUAD:
            begin
                quad_reg <= quad_next;
                r_reg    <= r_next;
            end
            diu_pkg::B_SQUARE:
            begin
                r2_reg    <= sq_prod[61:30];
                ts_reg    <= r_reg;
                tc_reg    <= Q30_ONE;
                sum_s_reg <= signed'(SW'(r_reg));
                sum_c_reg <= signed'(SW'(Q30_ONE));
                j_reg     <= 4'd1;
            end
            diu_pkg::B_TERM_MUL:
            begin
                ps_reg <= ps_prod[63:30];
                pc_reg <= pc_prod[63:30];
            end
            diu_pkg::B_TERM_DIV:
            begin
                if (term_done_s)
                begin
                    ts_reg <= term_q_s[31:0];
                    tc_reg <= term_q_c[31:0];
                    // odd terms subtract, even terms add
                    if (j_reg[0])
                    begin
                        sum_s_reg <= sum_s_reg - signed'(SW'(term_q_s));
                        sum_c_reg <= sum_c_reg - signed'(SW'(term_q_c));
                    end
                    else
                    begin
                        sum_s_reg <= sum_s_reg + signed'(SW'(term_q_s));
                        sum_c_reg <= sum_c_reg + signed'(SW'(term_q_c));
                    end
                    j_reg <= j_reg + 4'd1;
                end
            end
            diu_pkg::B_FINISH:
            begin
                cs_reg <= cs_next;
                sn_reg <= sn_next;
            end
            diu_pkg::B_STEP:
            begin
                stepx_reg <= STEP_W'(avg_reg) * STEP_W'(cs_reg);
                stepy_reg <= STEP_W'(avg_reg) * STEP_W'(sn_reg);
            end
            diu_pkg::B_ACC:
            begin
                if (out_load)
                begin
                    theta_out_reg <= theta_reg;
                end
            end
            default:
            begin
                j_reg <= j_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                acc_x_reg     <= acc_x_next;
                acc_y_reg     <= acc_y_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign theta     = theta_out_reg;
    assign pos_x     = acc_x_reg;
    assign pos_y     = acc_y_reg;

    `DIU_ASSERT_NOW(a_theta_range, out_valid_reg, theta_out_reg < TURN, "theta not below full turn")
    `DIU_ASSERT_NOW(a_lane_sync, 1'b1, (rad_done_l == rad_done_r) && (term_done_s == term_done_c), "divider lanes out of step")
    `DIU_ASSERT_NOW(a_term_range, state_reg == diu_pkg::B_TERM_DIV, (j_reg >= 4'd1) && (j_reg <= 4'(diu_pkg::TERM_LAST)), "series term index out of range")
    `DIU_ASSERT_NEXT(a_acc_hold, out_valid_reg && out_stall, $stable(acc_x_reg) && $stable(acc_y_reg), "position moved under a stalled result")

endmodule

`default_nettype wire

// ----- hw/rtl/dual_imu_odometry_update.sv -----
// Latency is set mostly by the series loop: 11 terms, each a multiply, a divider
//   start and a divide. The back end works on one sample at a time; the two-entry queue
//   takes up to two further samples while the back end works, then the input stalls.
// Reset (rst_n, asynchronous, active low) clears positions, previous counts,
//   heading offset, queue and output valid.
`default_nettype none

module dual_imu_odometry_update #(
    parameter int FRAC_BITS = diu_pkg::FRAC_BITS_DEF,
    parameter int POS_WIDTH = diu_pkg::POS_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [diu_pkg::HEAD_W-1:0]         left_heading,
    input  wire logic [diu_pkg::HEAD_W-1:0]         right_heading,
    input  wire logic signed [diu_pkg::COUNT_W-1:0] left_count,
    input  wire logic signed [diu_pkg::COUNT_W-1:0] right_count,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [FRAC_BITS+2:0]                    theta,
    output logic signed [POS_WIDTH-1:0]             pos_x,
    output logic signed [POS_WIDTH-1:0]             pos_y,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [FRAC_BITS+2:0]               heading_offset
);

    logic [FRAC_BITS+2:0]          offset_reg;
    diu_pkg::fifo_stat_t           stat;
    logic                          push, pop;
    logic [diu_pkg::FIFO_W-1:0]    push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            offset_reg <= heading_offset;
        end
    end

    diu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .left_heading  (left_heading),
        .right_heading (right_heading),
        .left_count    (left_count),
        .right_count   (right_count),
        .stat          (stat),
        .push          (push),
        .push_data     (push_data)
    );

    diu_fifo #(
        .WIDTH (diu_pkg::FIFO_W),
        .DEPTH (diu_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (stat)
    );

    diu_back #(
        .FRAC_BITS (FRAC_BITS),
        .POS_WIDTH (POS_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .offset    (offset_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .theta     (theta),
        .pos_x     (pos_x),
        .pos_y     (pos_y)
    );

endmodule

`default_nettype wire

// ----- dv/dual_imu_odometry_update_test.sv -----
// Self-checking testbench for the dual IMU odometry update block.
`timescale 1ns / 1ps

module dual_imu_odometry_update_test;

    localparam int FB = diu_pkg::FRAC_BITS_DEF;
    localparam int PW = diu_pkg::POS_WIDTH_DEF;
    localparam int AW = FB + 3;
    localparam longint unsigned TURN = diu_pkg::full_turn(FB);
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic [AW-1:0]        theta;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] left_heading = '0;
    logic [15:0] right_heading = '0;
    logic signed [31:0] left_count = '0;
    logic signed [31:0] right_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [AW-1:0] theta;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [AW-1:0] heading_offset = '0;

    pose_t pending_poses[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    // predictor state
    longint mdl_x = 0;
    longint mdl_y = 0;
    longint mdl_prev_l = 0;
    longint mdl_prev_r = 0;
    longint unsigned mdl_offset = 0;
    int last_l = 0;
    int last_r = 0;

    dual_imu_odometry_update dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .left_heading(left_heading), .right_heading(right_heading),
        .left_count(left_count), .right_count(right_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .theta(theta), .pos_x(pos_x), .pos_y(pos_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .heading_offset(heading_offset)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned mirrored_angle(longint unsigned h, longint unsigned off);
        longint unsigned m;
        longint unsigned rad;
        m = (h <= 36000) ? 36000 - h : h - 36000;
        rad = ((m * diu_pkg::PI44) / 18000 + (64'd1 << (43 - FB))) >> (44 - FB);
        rad = rad % TURN;
        return (rad >= off) ? rad - off : rad + TURN - off;
    endfunction

    function automatic longint taylor_q30(longint unsigned start, longint unsigned r2, int first);
        longint unsigned t;
        longint sum;
        int n;
        t = start;
        sum = 0;
        n = first;
        for (int k = 0; k < 12; k++) begin
            if (k % 2 == 1) sum -= longint'(t);
            else sum += longint'(t);
            t = ((t * r2) >> 30) / longint'((n + 1) * (n + 2));
            n += 2;
        end
        return (sum < 0) ? 0 : sum;
    endfunction

    function automatic longint to_frac(longint v);
        return longint'((unsigned'(v) + (64'd1 << (29 - FB))) >> (30 - FB));
    endfunction

    function automatic longint sat_accumulate(longint acc, longint d);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (PW - 1)) - 1;
        lo = -hi - 1;
        if (d > 0 && acc > hi - d) return hi;
        if (d < 0 && acc < lo - d) return lo;
        return acc + d;
    endfunction

    function automatic pose_t odometry_predict(logic [15:0] lh, logic [15:0] rh,
                                               logic signed [31:0] lc, logic signed [31:0] rc);
        longint unsigned off, th, hp, th30, q, r, r2;
        longint a1, a2, d, tt, m2, avg, c, s, cs, sn;
        pose_t p;
        tt = longint'(TURN);
        off = mdl_offset % TURN;
        a1 = longint'(mirrored_angle(lh, off));
        a2 = longint'(mirrored_angle(rh, off));
        d = a2 - a1;
        if (2 * d > tt) d -= tt;
        else if (2 * d < -tt) d += tt;
        if (2 * d == tt || 2 * d == -tt) begin
            th = TURN >> 1;
        end
        else begin
            m2 = 2 * a1 + d;
            if (m2 < 0) m2 += 2 * tt;
            if (m2 >= 2 * tt) m2 -= 2 * tt;
            th = (unsigned'(m2) + 1) >> 1;
            if (th >= TURN) th -= TURN;
        end
        avg = ((longint'(lc) - mdl_prev_l) + (longint'(rc) - mdl_prev_r)) / 2;
        mdl_prev_l = lc;
        mdl_prev_r = rc;
        hp = diu_pkg::PI44 >> 15;
        th30 = th << (30 - FB);
        q = th30 / hp;
        r = th30 - q * hp;
        r2 = (r * r) >> 30;
        s = to_frac(taylor_q30(r, r2, 1));
        c = to_frac(taylor_q30(64'd1 << 30, r2, 0));
        case (q % 4)
            0: begin cs = c;  sn = s;  end
            1: begin cs = -s; sn = c;  end
            2: begin cs = -c; sn = -s; end
            default: begin cs = s; sn = -c; end
        endcase
        mdl_x = sat_accumulate(mdl_x, avg * cs);
        mdl_y = sat_accumulate(mdl_y, avg * sn);
        p.theta = th[AW-1:0];
        p.x = mdl_x[PW-1:0];
        p.y = mdl_y[PW-1:0];
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Hold valid across consecutive transfers; drop it only for an idle gap.
    task automatic send_sample(logic [15:0] lh, logic [15:0] rh,
                               logic signed [31:0] lc, logic signed [31:0] rc);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        left_heading <= lh;
        right_heading <= rh;
        left_count <= lc;
        right_count <= rc;
        do @(posedge clk); while (in_stall !== 1'b0);
        pending_poses.push_back(odometry_predict(lh, rh, lc, rc));
        last_l = lc;
        last_r = rc;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_offset(logic [AW-1:0] v);
        cfg_valid <= 1'b1;
        heading_offset <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        mdl_offset = v;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_heading;
        if ($urandom_range(19) == 0) return 16'($urandom_range(65535));
        return 16'($urandom_range(35999));
    endfunction

    // Mostly small wheel motion, sometimes a jump anywhere in the count range.
    task automatic send_random(int count);
        int dl, dr;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0) begin
                send_sample(rand_heading(), rand_heading(), $urandom, $urandom);
            end
            else begin
                dl = $urandom_range(4000) - 2000;
                dr = $urandom_range(4000) - 2000;
                send_sample(rand_heading(), rand_heading(), last_l + dl, last_r + dr);
            end
        end
    endtask

    task automatic test_directed;
        send_sample(16'd0, 16'd0, 32'sd100, 32'sd100);
        send_sample(16'd36000, 16'd0, 32'sd300, 32'sd100);
        send_sample(16'd35999, 16'd1, -32'sd50, 32'sd70);
        send_sample(16'd0, 16'd18000, 32'sd1000, 32'sd1000);
        send_sample(16'd9000, 16'd27000, 32'sd2000, 32'sd1999);
        send_sample(16'd4500, 16'd4500, 32'sd2001, 32'sd1998);
        send_sample(16'd13500, 16'd22500, 32'sd5000, 32'sd5000);
        send_sample(16'd65535, 16'd36001, 32'sd5001, 32'sd5000);
        send_sample(16'd40000, 16'd32768, 32'sd5000, 32'sd5001);
        send_sample(16'd27000, 16'd27000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_sample(16'd27000, 16'd27000, 32'sh8000_0000, 32'sh8000_0000);
        send_sample(16'd9000, 16'd9000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_sample(16'd18000, 16'd18000, 32'sh8000_0000, 32'sh8000_0000);
        send_sample(16'd18000, 16'd18000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_sample(16'd0, 16'd0, 32'sh8000_0000, 32'sh8000_0000);
        send_sample(16'd0, 16'd0, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_sample(16'd0, 16'd0, 32'sh8000_0000, 32'sh8000_0000);
        send_sample(16'd0, 16'd0, 32'sh7fff_ffff, 32'sh8000_0000);
        drain();
    endtask

    task automatic test_offsets;
        logic [AW-1:0] offs[6];
        offs = '{AW'(1), AW'(TURN - 1), AW'(TURN), {AW{1'b1}},
                 AW'($urandom_range(TURN - 1)), AW'(0)};
        foreach (offs[i]) begin
            write_offset(offs[i]);
            send_sample(16'd0, 16'd0, last_l + 7, last_r + 9);
            send_sample(16'd35999, 16'd18000, last_l - 3, last_r + 1);
            send_random(20);
            drain();
        end
    endtask

    task automatic test_backpressure;
        hold_cycles = 1500;
        send_random(12);
        drain();
    endtask

    task automatic test_random;
        send_idle_pct = 25;
        recv_idle_pct = 71;
        send_random(450);
        send_idle_pct = 71;
        recv_idle_pct = 25;
        send_random(450);
        drain();
        write_offset(AW'($urandom_range(TURN - 1)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(400);
        drain();
    endtask

    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else begin
            out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        pose_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_poses.size() == 0) begin
                $display("MISMATCH unexpected result at %0t", $realtime);
                error_count++;
            end
            else begin
                want = pending_poses.pop_front();
                if (theta !== want.theta) report_mismatch("theta", theta, want.theta);
                if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
                if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_offsets();
        test_backpressure();
        test_random();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
